>>> hdl/aes_pkg.sv
package aes_pkg;

  localparam int unsigned KeyWords = 4;
  localparam int unsigned NumRounds = KeyWords + 6;
  localparam int unsigned SchedWords = 4 * (NumRounds + 1);
  localparam int unsigned NumRegs = 4;
  localparam int unsigned RegIdxW = 2;
  localparam int unsigned ExpSteps = SchedWords - KeyWords;
  localparam int unsigned StepW = $clog2(ExpSteps + 1);
  localparam int unsigned PhW = $clog2(KeyWords);
  localparam logic [PhW-1:0] PhLast = PhW'(KeyWords - 1);
  localparam logic [PhW-1:0] PhSub = PhW'(KeyWords > 6 ? 4 : 0);

  typedef logic [127:0] blk_t;
  typedef logic [31:0] word_t;

  typedef enum logic [RegIdxW-1:0] {
    REG_KEY0 = 2'd0,
    REG_KEY1 = 2'd1,
    REG_KEY2 = 2'd2,
    REG_KEY3 = 2'd3
  } reg_idx_e;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // byte k of a 128-bit block, byte 0 most significant
  function automatic logic [7:0] blk_byte(input blk_t b, input int unsigned k);
    return b[127-8*k -: 8];
  endfunction

endpackage

>>> hdl/aes_block_encrypt.sv
// channel | valid       | ready       | payload
// input   | in_valid_i  | in_ready_o  | block_high_i, block_low_i
// output  | out_valid_o | out_ready_i | cipher_high_o, cipher_low_o
// one item per cycle unless out_ready_i stalls the chain or round keys are being
// rebuilt; the pipeline is a whitening stage plus one cell per round.
// a stage holds only while it has an item and the stage after it holds, so
// bubbles are squeezed out as the chain moves.
// reset clears the valid bits and the key registers; after reset or a key write
// in_ready_o stays low while round keys are rebuilt.
module aes_block_encrypt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] block_high_i,
  input  logic [63:0] block_low_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] cipher_high_o,
  output logic [63:0] cipher_low_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);
  import aes_pkg::*;

  logic [NumRounds:0][127:0] rkeys;
  logic [NumRounds:0] vld;
  blk_t st [NumRounds+1];
  logic [NumRounds:0] en;
  logic key_busy;

  aes_key_sched u_sched (
    .clk_i, .rst_ni,
    .wr_en_i(cfg_we_i), .wr_idx_i(cfg_idx_i), .wr_data_i(cfg_data_i),
    .busy_o(key_busy),
    .rkeys_o(rkeys)
  );

  // a stage moves when it is empty or the stage after it moves
  always_comb begin
    en[NumRounds] = !vld[NumRounds] || out_ready_i;
    for (int i = NumRounds - 1; i >= 0; i--) en[i] = !vld[i] || en[i+1];
  end

  assign in_ready_o = en[0] && !key_busy;

  // whitening stage: initial key add
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld[0] <= 1'b0;
    else if (en[0]) vld[0] <= in_valid_i && !key_busy;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) st[0] <= {block_high_i, block_low_i} ^ rkeys[0];
  end

  for (genvar g = 1; g <= NumRounds; g++) begin : g_cell
    aes_round_cell u_cell (
      .clk_i, .rst_ni,
      .en_i(en[g]),
      .last_i(g == NumRounds),
      .valid_i(vld[g-1]),
      .state_i(st[g-1]),
      .rkey_i(rkeys[g]),
      .valid_o(vld[g]),
      .state_o(st[g])
    );
  end

  assign out_valid_o   = vld[NumRounds];
  assign cipher_high_o = st[NumRounds][127:64];
  assign cipher_low_o  = st[NumRounds][63:0];
endmodule

>>> hdl/aes_key_sched.sv
// round key schedule, rebuilt one word per cycle after reset or a key write
module aes_key_sched (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      wr_en_i,
  input  logic [1:0]                wr_idx_i,
  input  logic [63:0]               wr_data_i,
  output logic                      busy_o,
  output logic [aes_pkg::NumRounds:0][127:0] rkeys_o
);
  import aes_pkg::*;

  logic [63:0] key_q [NumRegs];
  logic [255:0] key_flat;
  word_t sw_q [SchedWords];
  logic load_q;
  logic [StepW-1:0] cnt_q;
  logic [PhW-1:0] ph_q;
  logic [7:0] rc_q;
  word_t t;
  word_t nw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) key_q[i] <= '0;
    end else if (wr_en_i) begin
      key_q[wr_idx_i] <= wr_data_i;
    end
  end

  assign key_flat = {key_q[0], key_q[1], key_q[2], key_q[3]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= 1'b1;
      cnt_q <= '0;
      ph_q <= '0;
      rc_q <= 8'h01;
    end else if (wr_en_i) begin
      load_q <= 1'b1;
      cnt_q <= '0;
    end else if (load_q) begin
      load_q <= 1'b0;
      cnt_q <= StepW'(ExpSteps);
      ph_q <= '0;
      rc_q <= 8'h01;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
      ph_q <= (ph_q == PhLast) ? '0 : ph_q + 1'b1;
      if (ph_q == '0) rc_q <= xtime(rc_q);
    end
  end

  // next schedule word from the newest word and the one KeyWords back
  always_comb begin
    t = sw_q[SchedWords-1];
    if (ph_q == '0) begin
      t = {SBOX[t[23:16]] ^ rc_q, SBOX[t[15:8]], SBOX[t[7:0]], SBOX[t[31:24]]};
    end else if (KeyWords > 6 && ph_q == PhSub) begin
      t = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
    end
    nw = sw_q[SchedWords-KeyWords] ^ t;
  end

  // key words enter at the tail and shift down until word i sits at slot i
  always_ff @(posedge clk_i) begin
    if (load_q) begin
      for (int j = 0; j < KeyWords; j++)
        sw_q[SchedWords-KeyWords+j] <= key_flat[255-32*j -: 32];
    end else if (cnt_q != '0) begin
      for (int j = 0; j < SchedWords - 1; j++) sw_q[j] <= sw_q[j+1];
      sw_q[SchedWords-1] <= nw;
    end
  end

  assign busy_o = load_q || (cnt_q != '0);

  always_comb begin
    for (int r = 0; r <= NumRounds; r++)
      rkeys_o[r] = {sw_q[4*r], sw_q[4*r+1], sw_q[4*r+2], sw_q[4*r+3]};
  end
endmodule

>>> hdl/aes_round_cell.sv
// one round stage: sub bytes, shift rows, optional mix columns, key add
module aes_round_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               last_i,
  input  logic               valid_i,
  input  aes_pkg::blk_t      state_i,
  input  aes_pkg::blk_t      rkey_i,
  output logic               valid_o,
  output aes_pkg::blk_t      state_o
);
  import aes_pkg::*;

  logic [7:0] s [16];
  logic [7:0] t [16];
  logic [7:0] m [16];
  blk_t nxt;

  always_comb begin
    logic [7:0] all;
    for (int k = 0; k < 16; k++) s[k] = blk_byte(state_i, k);
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) t[4*c+r] = SBOX[s[4*((c+r)%4)+r]];
    for (int c = 0; c < 4; c++) begin
      all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
      for (int r = 0; r < 4; r++)
        m[4*c+r] = t[4*c+r] ^ all ^ xtime(t[4*c+r] ^ t[4*c+((r+1)%4)]);
    end
    for (int k = 0; k < 16; k++)
      nxt[127-8*k -: 8] = (last_i ? t[k] : m[k]) ^ blk_byte(rkey_i, k);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) state_o <= nxt;
  end
endmodule

>>> tb/aes_cipher_checker.sv
`timescale 1ns / 100ps

module aes_cipher_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [63:0] block_high_i,
  input  logic [63:0] block_low_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [63:0] cipher_high_i,
  input  logic [63:0] cipher_low_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          blocks_done_o
);
  import aes_pkg::*;

  logic [63:0] key_regs [NumRegs];
  logic [127:0] cipher_q [$];

  localparam logic [7:0] SUB [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] gf_double(logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] encrypt_block(logic [127:0] plain);
    logic [7:0] sched [SchedWords][4];
    logic [7:0] st [16];
    logic [7:0] tmp [16];
    logic [7:0] t [4];
    logic [7:0] rcon, x, a0, a1, a2, a3, all;
    logic [255:0] key;
    logic [127:0] res;
    key = {key_regs[0], key_regs[1], key_regs[2], key_regs[3]};
    rcon = 8'h01;
    for (int i = 0; i < KeyWords; i++)
      for (int j = 0; j < 4; j++) sched[i][j] = key[255 - 8*(4*i+j) -: 8];
    for (int i = KeyWords; i < SchedWords; i++) begin
      for (int j = 0; j < 4; j++) t[j] = sched[i-1][j];
      if (i % KeyWords == 0) begin
        x = t[0];
        t[0] = SUB[t[1]] ^ rcon;
        t[1] = SUB[t[2]];
        t[2] = SUB[t[3]];
        t[3] = SUB[x];
        rcon = gf_double(rcon);
      end else if (KeyWords > 6 && i % KeyWords == 4) begin
        for (int j = 0; j < 4; j++) t[j] = SUB[t[j]];
      end
      for (int j = 0; j < 4; j++) sched[i][j] = sched[i-KeyWords][j] ^ t[j];
    end
    for (int k = 0; k < 16; k++) st[k] = plain[127 - 8*k -: 8];
    for (int rnd = 0; rnd <= NumRounds; rnd++) begin
      if (rnd > 0) begin
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) tmp[4*c+r] = SUB[st[4*((c+r)%4)+r]];
        st = tmp;
      end
      if (rnd > 0 && rnd < NumRounds) begin
        for (int c = 0; c < 4; c++) begin
          a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
          all = a0 ^ a1 ^ a2 ^ a3;
          st[4*c]   = a0 ^ all ^ gf_double(a0 ^ a1);
          st[4*c+1] = a1 ^ all ^ gf_double(a1 ^ a2);
          st[4*c+2] = a2 ^ all ^ gf_double(a2 ^ a3);
          st[4*c+3] = a3 ^ all ^ gf_double(a3 ^ a0);
        end
      end
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) st[4*c+r] ^= sched[4*rnd+c][r];
    end
    for (int k = 0; k < 16; k++) res[127 - 8*k -: 8] = st[k];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    blocks_done_o = 0;
    for (int i = 0; i < NumRegs; i++) key_regs[i] = '0;
  end

  assign pending_o = cipher_q.size();

  always @(posedge clk_i) begin
    logic [127:0] want;
    if (rst_ni) begin
      // output side first: a new item cannot leave in the cycle it enters
      if (out_valid_i && out_ready_i) begin
        blocks_done_o++;
        if (cipher_q.size() == 0) begin
          $display("unexpected cipher item %h_%h", cipher_high_i, cipher_low_i);
          fail_count_o++;
        end else begin
          want = cipher_q.pop_front();
          if (cipher_high_i !== want[127:64])
            report_mismatch("cipher_high", cipher_high_i, want[127:64]);
          if (cipher_low_i !== want[63:0])
            report_mismatch("cipher_low", cipher_low_i, want[63:0]);
        end
      end
      if (in_valid_i && in_ready_i)
        cipher_q.push_back(encrypt_block({block_high_i, block_low_i}));
      if (cfg_we_i) key_regs[cfg_idx_i] = cfg_data_i;
    end
  end
endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import aes_pkg::*;

  localparam int CycleLimit = 1000000;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic [63:0] block_high_i, block_low_i, cipher_high_o, cipher_low_o;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [63:0] cfg_data_i;
  int fail_count, pending, blocks_done, cycles;
  int send_idle_pct, stall_pct, sent;
  logic long_hold;

  aes_block_encrypt dut (.*);

  aes_cipher_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .block_high_i, .block_low_i,
    .out_valid_i(out_valid_o), .out_ready_i, .cipher_high_i(cipher_high_o),
    .cipher_low_i(cipher_low_o), .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending), .blocks_done_o(blocks_done)
  );

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("timeout after %0d cycles", cycles);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // receiver: random stall, or a long hold-off when asked
  initial begin
    out_ready_i = 0;
    forever begin
      @(negedge clk_i);
      if (long_hold) out_ready_i <= 0;
      else out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] edgy64();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h1;
      default: return rand64();
    endcase
  endfunction

  // valid stays up after an item until the next item or an idle cycle
  task automatic send_block(logic [63:0] hi, logic [63:0] lo);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(negedge clk_i);
    end
    in_valid_i <= 1;
    block_high_i <= hi;
    block_low_i <= lo;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    sent++;
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (pending != 0) @(negedge clk_i);
    repeat (NumRounds + 4) @(negedge clk_i);
  endtask

  task automatic write_key(reg_idx_e idx, logic [63:0] val);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
  endtask

  task automatic load_key(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                          logic [63:0] k3);
    drain();
    write_key(REG_KEY0, k0);
    write_key(REG_KEY1, k1);
    write_key(REG_KEY2, k2);
    write_key(REG_KEY3, k3);
    cfg_we_i <= 0;
    repeat (2) @(negedge clk_i);
  endtask

  initial begin
    rst_ni = 0;
    in_valid_i = 0;
    block_high_i = '0;
    block_low_i = '0;
    cfg_we_i = 0;
    cfg_idx_i = REG_KEY0;
    cfg_data_i = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    long_hold = 0;
    sent = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed: reset key, then the standard test key, extreme blocks
    send_block('0, '0);
    send_block('1, '1);
    load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617,
             64'h18191a1b1c1d1e1f);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block('0, '0);
    send_block('1, '1);
    send_block(64'h8000_0000_0000_0000, 64'h1);
    load_key('1, '1, '1, '1);
    send_block('0, '0);
    send_block('1, '1);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    // unused key bytes must not matter
    load_key('1, '1, '0, '0);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    load_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, '0, '0);
    send_block(64'h3243f6a8885a308d, 64'h313198a2e0370734);

    // back-pressure: fill the pipeline while the receiver holds off
    long_hold = 1;
    fork
      repeat (3 * NumRounds) send_block(rand64(), rand64());
      begin
        repeat (200) @(negedge clk_i);
        long_hold = 0;
      end
    join
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 82; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 82; end
        default: begin send_idle_pct = 9; stall_pct = 9; end
      endcase
      if (phase == 7) load_key('0, '0, '0, '0);
      else if (phase == 6) load_key('1, '1, '1, '1);
      else load_key(edgy64(), edgy64(), edgy64(), edgy64());
      repeat (210) send_block(edgy64(), edgy64());
    end
    drain();
    $display("sent %0d blocks, %0d ciphertexts checked, key changes under", sent,
             blocks_done);
    $display("idle/stall mixes and a full-pipeline hold-off");
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
